FILE: rtl/osp_pkg.sv
// Shared types and constants of the output state packet decoder.
package osp_pkg;

  localparam int PORTS      = 32;
  localparam int PORT_W     = 5;
  localparam int PORT_CNT_W = 6;
  localparam int HDR_CNT_W  = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        code;
    logic [1:0]        status;
    logic              run_end;
    logic              packet_end;
  } result_t;

endpackage

FILE: rtl/osp_front.sv
// Input side: accepts packet bytes and queues them for the decode sequencer.
module osp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                q_valid,
  output osp_pkg::byte_word_t q_word,
  input  logic                q_pop
);

  osp_pkg::byte_word_t                    mem_r [osp_pkg::Q_DEPTH];
  logic [osp_pkg::Q_PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [osp_pkg::Q_PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [osp_pkg::Q_CNT_W-1:0]            count_r, count_nxt;
  logic                                   push;
  logic                                   pop;

  assign in_stall = (count_r == osp_pkg::Q_CNT_W'(osp_pkg::Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_word   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, last: in_last_byte};
    end
  end

endmodule

FILE: rtl/osp_back.sv
// Decode sequencer: builds the header, emits one port result per cycle into the output register unless stalled.
module osp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  osp_pkg::byte_word_t q_word,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output osp_pkg::result_t    out_res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [31:0]                     full_mask_r, full_mask_nxt;
  logic [31:0]                     plain_bits_r, plain_bits_nxt;
  logic [osp_pkg::HDR_CNT_W-1:0]   hc_r, hc_nxt;
  logic [osp_pkg::PORT_CNT_W-1:0]  np_r, np_nxt;
  logic                            done_r, done_nxt;
  logic                            out_valid_r;
  osp_pkg::result_t                res_r;
  osp_pkg::result_t                res_nxt;
  logic                            emit_en;
  logic                            can_emit;
  logic [osp_pkg::PORT_CNT_W-1:0]  np_inc;
  logic                            np_last;
  logic                            masked_cur;
  logic                            masked_nxt;
  logic                            plain_cur;

  assign can_emit   = !out_valid_r || !out_stall;
  assign np_inc     = np_r + 1'b1;
  assign np_last    = (np_r == osp_pkg::PORT_CNT_W'(osp_pkg::PORTS - 1));
  assign masked_cur = full_mask_r[np_r[osp_pkg::PORT_W-1:0]];
  assign plain_cur  = plain_bits_r[np_r[osp_pkg::PORT_W-1:0]];
  assign masked_nxt = !np_last && full_mask_r[np_inc[osp_pkg::PORT_W-1:0]];

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt      = state_r;
    full_mask_nxt  = full_mask_r;
    plain_bits_nxt = plain_bits_r;
    hc_nxt         = hc_r;
    np_nxt         = np_r;
    done_nxt       = done_r;
    q_pop          = 1'b0;
    emit_en        = 1'b0;
    res_nxt.port       = np_r[osp_pkg::PORT_W-1:0];
    res_nxt.code       = 8'd0;
    res_nxt.status     = osp_pkg::ST_OK;
    res_nxt.run_end    = 1'b0;
    res_nxt.packet_end = np_last;

    if (can_emit) begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            q_pop = 1'b1;
            if (!hc_r[3]) begin
              // Header byte: fill the mask lanes first, then the plain lanes.
              if (hc_r[2]) begin
                plain_bits_nxt[{hc_r[1:0], 3'b000} +: 8] = q_word.data;
              end else begin
                full_mask_nxt[{hc_r[1:0], 3'b000} +: 8] = q_word.data;
              end
              hc_nxt = hc_r + 1'b1;
              if (hc_r == osp_pkg::HDR_CNT_W'(7)) begin
                np_nxt = '0;
                if (q_word.last) begin
                  state_nxt = S_FLUSH;
                end else if (!full_mask_r[0]) begin
                  state_nxt = S_RUN;
                end
              end else if (q_word.last) begin
                emit_en            = 1'b1;
                res_nxt.port       = '0;
                res_nxt.status     = osp_pkg::ST_SHORT;
                res_nxt.run_end    = 1'b1;
                res_nxt.packet_end = 1'b1;
                hc_nxt             = '0;
                np_nxt             = '0;
                done_nxt           = 1'b0;
              end
            end else if (!done_r) begin
              // Full code byte for the current masked port.
              emit_en         = 1'b1;
              res_nxt.code    = q_word.data;
              res_nxt.run_end = q_word.last ? np_last : (np_last || masked_nxt);
              np_nxt          = np_inc;
              if (np_last) begin
                done_nxt = 1'b1;
                if (q_word.last) begin
                  hc_nxt   = '0;
                  np_nxt   = '0;
                  done_nxt = 1'b0;
                end
              end else if (q_word.last) begin
                state_nxt = S_FLUSH;
              end else if (!masked_nxt) begin
                state_nxt = S_RUN;
              end
            end else if (q_word.last) begin
              hc_nxt   = '0;
              np_nxt   = '0;
              done_nxt = 1'b0;
            end
          end
        end
        S_RUN: begin
          emit_en         = 1'b1;
          res_nxt.code    = {7'd0, plain_cur};
          res_nxt.run_end = np_last || masked_nxt;
          np_nxt          = np_inc;
          if (np_last) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (masked_nxt) begin
            state_nxt = S_IDLE;
          end
        end
        S_FLUSH: begin
          emit_en         = 1'b1;
          res_nxt.code    = masked_cur ? 8'd0 : {7'd0, plain_cur};
          res_nxt.status  = masked_cur ? osp_pkg::ST_MISSING : osp_pkg::ST_OK;
          res_nxt.run_end = np_last;
          np_nxt          = np_inc;
          if (np_last) begin
            state_nxt = S_IDLE;
            hc_nxt    = '0;
            np_nxt    = '0;
            done_nxt  = 1'b0;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hc_r        <= '0;
      np_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hc_r    <= hc_nxt;
      np_r    <= np_nxt;
      done_r  <= done_nxt;
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    full_mask_r  <= full_mask_nxt;
    plain_bits_r <= plain_bits_nxt;
    if (emit_en) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/output_state_packet_decoder_core.sv
// Top level of the output state packet decoder: input queue plus decode sequencer.
//
// The input channel takes one packet byte per word (in_data_byte, with
// in_last_byte on the final byte). Bytes 0 to 3 are the little-endian full-code
// mask, bytes 4 to 7 the plain output bits, and each further byte the code of the
// next masked port. The output channel gives one word per port, in port order,
// with out_run_end on the last word caused by an input byte and out_packet_end on
// the last word of the packet. A packet that ends inside its header gives one
// word with status "header too short"; masked ports that never got a byte are
// sent at packet end with code 0 and status "full byte missing".
// With the sequencer free, a full code byte, or a last byte inside the header,
// goes through the input queue and then the output register; the eighth header
// byte goes through the input queue, sets the sequencer state, and its first
// word then goes out through the output register. The sequencer pops one byte
// per cycle and emits one word per cycle, each while out_stall does not hold it,
// and pops no new byte while words that a byte caused are still going out; the
// single output register bounds it. A four-word input queue lets bytes arrive
// while words are still going out; in_stall rises only when that queue is full.
// While out_stall is high and a word is pending, the output word holds and the
// sequencer waits. Reset empties the queue, drops any pending output word and
// returns the decoder to the start of a packet.
module output_state_packet_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_port,
  output logic [7:0] out_code,
  output logic [1:0] out_status,
  output logic       out_run_end,
  output logic       out_packet_end
);

  // Bytes waiting between the input side and the sequencer.
  logic                q_valid;
  logic                q_pop;
  osp_pkg::byte_word_t q_word;
  osp_pkg::result_t    res;

  osp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop)
  );

  // The sequencer owns the header state and the registered output word.
  osp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_port       = res.port;
  assign out_code       = res.code;
  assign out_status     = res.status;
  assign out_run_end    = res.run_end;
  assign out_packet_end = res.packet_end;

endmodule

FILE: tb/tb_output_state_packet_decoder_core.sv
// Self-checking testbench for the output state packet decoder core.

// Keeps a model of the decoder state. For every accepted input word it predicts
// the port words that the core must send, and it checks the words that come out.
class port_word_scoreboard;
  osp_pkg::result_t pending_words[$];

  // Decoder state of the current packet.
  logic [31:0] full_mask;
  logic [31:0] plain_bits;
  int unsigned header_count;
  int unsigned next_port;
  bit          ports_done;

  int errors;
  int words_checked;
  int bytes_noted;
  int packets_seen;
  int short_packets;
  int missing_words;

  function new();
    clear_state();
    errors = 0;
    words_checked = 0;
    bytes_noted = 0;
    packets_seen = 0;
    short_packets = 0;
    missing_words = 0;
  endfunction

  function void clear_state();
    full_mask    = '0;
    plain_bits   = '0;
    header_count = 0;
    next_port    = 0;
    ports_done   = 1'b0;
  endfunction

  function void push_word(int unsigned p, logic [7:0] code, logic [1:0] st);
    osp_pkg::result_t w;
    w.port       = 5'(p);
    w.code       = code;
    w.status     = st;
    w.run_end    = 1'b0;
    w.packet_end = (st == osp_pkg::ST_SHORT) || (p == osp_pkg::PORTS - 1);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Reports every plain port up to the next masked one.
  function void push_plain_run();
    while (next_port < osp_pkg::PORTS && !full_mask[next_port]) begin
      push_word(next_port, {7'd0, plain_bits[next_port]}, osp_pkg::ST_OK);
      next_port++;
    end
    if (next_port >= osp_pkg::PORTS) ports_done = 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    int first_new;
    first_new = pending_words.size();
    bytes_noted++;
    if (header_count < 8) begin
      if (header_count < 4) full_mask |= 32'(b) << (8 * header_count);
      else plain_bits |= 32'(b) << (8 * (header_count - 4));
      header_count++;
      if (header_count == 8) push_plain_run();
    end else if (!ports_done) begin
      push_word(next_port, b, osp_pkg::ST_OK);
      next_port++;
      push_plain_run();
    end
    if (last) begin
      packets_seen++;
      if (header_count < 8) begin
        push_word(0, 8'd0, osp_pkg::ST_SHORT);
        short_packets++;
      end else begin
        while (next_port < osp_pkg::PORTS) begin
          if (full_mask[next_port]) begin
            push_word(next_port, 8'd0, osp_pkg::ST_MISSING);
            missing_words++;
          end else begin
            push_word(next_port, {7'd0, plain_bits[next_port]}, osp_pkg::ST_OK);
          end
          next_port++;
        end
      end
      clear_state();
    end
    if (pending_words.size() > first_new)
      pending_words[pending_words.size() - 1].run_end = 1'b1;
  endfunction

  function void report(string what, osp_pkg::result_t want, osp_pkg::result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected port %0d code %02h status %0d run_end %0b packet_end %0b,",
               what, want.port, want.code, want.status, want.run_end, want.packet_end);
      $display("  got port %0d code %02h status %0d run_end %0b packet_end %0b",
               got.port, got.code, got.status, got.run_end, got.packet_end);
    end
  endfunction

  function void check_word(logic [4:0] port, logic [7:0] code, logic [1:0] status,
                           logic run_end, logic packet_end);
    osp_pkg::result_t got;
    osp_pkg::result_t want;
    got.port       = port;
    got.code       = code;
    got.status     = status;
    got.run_end    = run_end;
    got.packet_end = packet_end;
    words_checked++;
    if (pending_words.size() == 0) begin
      want = '0;
      report("word with nothing pending", want, got);
    end else begin
      want = pending_words.pop_front();
      if (got.port !== want.port || got.code !== want.code || got.status !== want.status ||
          got.run_end !== want.run_end || got.packet_end !== want.packet_end)
        report("word mismatch", want, got);
    end
  endfunction
endclass

module tb_output_state_packet_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_port;
  logic [7:0] out_code;
  logic [1:0] out_status;
  logic       out_run_end;
  logic       out_packet_end;

  // Chance in percent that the sender idles or the receiver stalls in a cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Set while the receiver holds off for a long stretch to fill the core up.
  logic hold_req = 1'b0;
  // Input words that the core acts on; ignored trailing bytes are not counted.
  int useful_bytes = 0;

  port_word_scoreboard sb;

  output_state_packet_decoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_port      (out_port),
    .out_code      (out_code),
    .out_status    (out_status),
    .out_run_end   (out_run_end),
    .out_packet_end(out_packet_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run: far beyond the slowest correct run, even if every
  // packet is all ports.
  initial begin
    #2_000_000;
    $display("[output_state_packet_decoder_core] ERROR");
    $finish;
  end

  // Receiver: a word is taken at an edge where out_valid is high and out_stall
  // is low. Both are sampled before this edge's updates land, so the check
  // sees exactly what the core saw. The next stall value is then chosen for the
  // coming cycle, forced high while the long hold-off is running.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_port, out_code, out_status, out_run_end, out_packet_end);
    out_stall <= hold_req || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off on the output side. It starts during the directed packets,
  // which are sent with no idling, so the four-word input queue fills up and
  // the core has to raise in_stall.
  initial begin
    wait (rst_n === 1'b1);
    repeat (60) @(posedge clk);
    hold_req <= 1'b1;
    repeat (400) @(posedge clk);
    hold_req <= 1'b0;
  end

  // Offers one word and returns at the edge where it is accepted. Any idle
  // cycles come first, so valid is never dropped and raised in one step, and
  // the word stays unchanged for as long as the core stalls it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
  endtask

  // Sends the first count header bytes, little-endian mask then plain bits,
  // closing the packet on the last of them when close is set.
  task automatic send_header(input logic [31:0] mask, input logic [31:0] plain,
                             input int unsigned count, input bit close);
    for (int i = 0; i < count; i++)
      send_byte(i < 4 ? mask[8*i +: 8] : plain[8*(i-4) +: 8], close && i == count - 1);
  endtask

  // A packet of len bytes: the header (cut short if len is below eight) and
  // random full code bytes after it.
  task automatic send_packet(input logic [31:0] mask, input logic [31:0] plain,
                             input int unsigned len);
    send_header(mask, plain, len < 8 ? len : 8, len <= 8);
    for (int i = 8; i < len; i++)
      send_byte(8'($urandom), i == len - 1);
  endtask

  // One random packet. Most are complete: header plus one byte per masked
  // port, now and then with trailing bytes that the core ignores. The rest
  // end before all full bytes came or even inside the header.
  task automatic send_random_packet();
    logic [31:0] mask;
    logic [31:0] plain;
    int unsigned masked;
    int unsigned len;
    int unsigned extra;
    int unsigned pick;
    extra = 0;
    plain = $urandom;
    case ($urandom_range(3))
      0:       mask = 32'h0000_0000;
      1:       mask = 32'hFFFF_FFFF;
      2:       mask = $urandom & $urandom & $urandom;
      default: mask = $urandom;
    endcase
    masked = $countones(mask);
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = 8 + masked;
      if ($urandom_range(3) == 0) extra = $urandom_range(1, 3);
    end else if (pick < 85) begin
      len = (masked == 0) ? 8 : 8 + $urandom_range(masked - 1);
    end else begin
      len = $urandom_range(1, 7);
    end
    send_packet(mask, plain, len + extra);
    useful_bytes += len;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets, sent with no idling and during the early hold-off.
    // A single closing byte is a header that is far too short.
    send_packet(32'hFFFF_FFFF, 32'h0000_0000, 1);
    // Seven bytes: the header misses only its final byte.
    send_packet(32'h0000_0000, 32'hFFFF_FFFF, 7);
    // Ports 0 and 31 masked: the first full byte reports port 0 and then the
    // whole plain run up to port 30, the second one port 31, after which the
    // closing byte is ignored.
    send_header(32'h8000_0001, 32'hAAAA_5555, 8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    // Every port masked and the packet closed right at the end of the header,
    // so all 32 ports go out as missing with code zero.
    send_packet(32'hFFFF_FFFF, 32'h0000_0000, 8);
    useful_bytes = 26;

    // Random packets in four phases of idling: none, sender only, receiver
    // only, and both sides lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      while (useful_bytes < (phase + 1) * 108)
        send_random_packet();
    end
    in_valid <= 1'b0;

    // Drain: every predicted word must arrive, then a quiet stretch catches
    // any word the core sends beyond them.
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d packets in %0d bytes: %0d short headers, %0d ports without a full byte,",
             sb.packets_seen, sb.bytes_noted, sb.short_packets, sb.missing_words);
    $display("idle and stall phases plus a long output hold-off; %0d words checked.",
             sb.words_checked);
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("[output_state_packet_decoder_core] OK");
    else
      $display("[output_state_packet_decoder_core] ERROR");
    $finish;
  end

endmodule
